>>> hw/rtl/sacr_pkg.sv
// Shared widths, payload types and helper functions of the swept box collision pipeline.
package sacr_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
    localparam int TIME_BITS   = 16;
    localparam int NORM_WIDTH  = 16;
    localparam int DIST_WIDTH  = COORD_WIDTH + 2;
    localparam int DEN_WIDTH   = COORD_WIDTH;
    localparam int PROD_WIDTH  = DIST_WIDTH + DEN_WIDTH + 1;
    localparam int CTR_WIDTH   = COORD_WIDTH + 1;
    localparam int REM_WIDTH   = COORD_WIDTH + 1;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_STAGES  = TIME_BITS / DIV_STEPS;
    localparam int SAT_WIDTH   = COORD_WIDTH + 4;
    localparam int CPROD_WIDTH = COORD_WIDTH + TIME_BITS + 1;
    localparam int MPROD_WIDTH = COORD_WIDTH + TIME_BITS + 1;
    localparam int MAG_WIDTH   = COORD_WIDTH + 1;
    localparam int NMAG_WIDTH  = NORM_WIDTH - 1;

    localparam logic signed [NORM_WIDTH-1:0] NORM_ONE  = NORM_WIDTH'(16384);
    localparam logic signed [NORM_WIDTH-1:0] NORM_DIAG = NORM_WIDTH'(11585);

    localparam logic signed [SAT_WIDTH-1:0] SAT_HI =
        {{(SAT_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SAT_WIDTH-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [1:0] {
        KIND_NEG = 2'b00,
        KIND_FIN = 2'b01,
        KIND_POS = 2'b10
    } kind_t;

    typedef enum logic [1:0] {
        ORD_LT = 2'b00,
        ORD_EQ = 2'b01,
        ORD_GT = 2'b10
    } ord_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] mover_x;
        logic signed [COORD_WIDTH-1:0] mover_y;
        logic        [SIZE_WIDTH-1:0]  mover_w;
        logic        [SIZE_WIDTH-1:0]  mover_h;
        logic signed [COORD_WIDTH-1:0] vel_x;
        logic signed [COORD_WIDTH-1:0] vel_y;
        logic signed [COORD_WIDTH-1:0] target_x;
        logic signed [COORD_WIDTH-1:0] target_y;
        logic        [SIZE_WIDTH-1:0]  target_w;
        logic        [SIZE_WIDTH-1:0]  target_h;
    } in_t;

    typedef struct packed {
        logic signed [DIST_WIDTH-1:0] near_num;
        logic signed [DIST_WIDTH-1:0] far_num;
        logic        [DEN_WIDTH-1:0]  den;
        kind_t                        near_kind;
        kind_t                        far_kind;
        logic                         miss;
    } axis_t;

    typedef struct packed {
        axis_t                         ax;
        axis_t                         ay;
        logic signed [COORD_WIDTH-1:0] vel_x;
        logic signed [COORD_WIDTH-1:0] vel_y;
        logic signed [CTR_WIDTH-1:0]   ctr_x;
        logic signed [CTR_WIDTH-1:0]   ctr_y;
        logic                          odd_x;
        logic                          odd_y;
    } s1_t;

    typedef struct packed {
        s1_t                          s;
        logic signed [PROD_WIDTH-1:0] p_xy_a;
        logic signed [PROD_WIDTH-1:0] p_xy_b;
        logic signed [PROD_WIDTH-1:0] p_yx_a;
        logic signed [PROD_WIDTH-1:0] p_yx_b;
        logic signed [PROD_WIDTH-1:0] p_nn_a;
        logic signed [PROD_WIDTH-1:0] p_nn_b;
    } s2_t;

    typedef struct packed {
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] vel_x;
        logic signed [COORD_WIDTH-1:0] vel_y;
        logic signed [CTR_WIDTH-1:0]   ctr_x;
        logic signed [CTR_WIDTH-1:0]   ctr_y;
        logic                          odd_x;
        logic                          odd_y;
        logic signed [NORM_WIDTH-1:0]  norm_x;
        logic signed [NORM_WIDTH-1:0]  norm_y;
    } ctx_t;

    typedef struct packed {
        ctx_t                 ctx;
        logic [REM_WIDTH-1:0] rem;
        logic [DEN_WIDTH-1:0] den;
        logic [TIME_BITS-1:0] tq;
    } div_t;

    typedef struct packed {
        logic                          hit;
        logic [TIME_BITS-1:0]          entry_time;
        logic signed [COORD_WIDTH-1:0] contact_x;
        logic signed [COORD_WIDTH-1:0] contact_y;
        logic signed [NORM_WIDTH-1:0]  normal_x;
        logic signed [NORM_WIDTH-1:0]  normal_y;
        logic signed [COORD_WIDTH-1:0] new_vel_x;
        logic signed [COORD_WIDTH-1:0] new_vel_y;
    } out_t;

    function automatic axis_t axis_setup(
        input logic signed [COORD_WIDTH-1:0] pos,
        input logic        [SIZE_WIDTH-1:0]  size,
        input logic signed [COORD_WIDTH-1:0] vel,
        input logic signed [COORD_WIDTH-1:0] tpos,
        input logic        [SIZE_WIDTH-1:0]  tsize
    );
        axis_t a;
        logic signed [DIST_WIDTH-1:0] dn;
        logic signed [DIST_WIDTH-1:0] df;
        dn = DIST_WIDTH'(tpos) - DIST_WIDTH'(pos) - DIST_WIDTH'(size);
        df = DIST_WIDTH'(tpos) + DIST_WIDTH'(tsize) - DIST_WIDTH'(pos);
        a.den = vel[COORD_WIDTH-1] ? (~vel + 1'b1) : vel;
        if (vel[COORD_WIDTH-1])
        begin
            a.near_num = -df;
            a.far_num  = -dn;
        end
        else
        begin
            a.near_num = dn;
            a.far_num  = df;
        end
        if (vel == '0)
        begin
            a.near_kind = (dn > 0) ? KIND_POS : KIND_NEG;
            a.far_kind  = (df > 0) ? KIND_POS : KIND_NEG;
        end
        else
        begin
            a.near_kind = KIND_FIN;
            a.far_kind  = KIND_FIN;
        end
        a.miss = (vel == '0) && ((dn == '0) || (df == '0));
        return a;
    endfunction

    // pa = a.num * b.den, pb = b.num * a.den
    function automatic ord_t cmp_time(
        input kind_t                        ka,
        input kind_t                        kb,
        input logic signed [PROD_WIDTH-1:0] pa,
        input logic signed [PROD_WIDTH-1:0] pb
    );
        ord_t r;
        if (ka != kb)
            r = (ka < kb) ? ORD_LT : ORD_GT;
        else if (ka != KIND_FIN)
            r = ORD_EQ;
        else if (pa < pb)
            r = ORD_LT;
        else if (pa == pb)
            r = ORD_EQ;
        else
            r = ORD_GT;
        return r;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [SAT_WIDTH-1:0] x
    );
        logic signed [COORD_WIDTH-1:0] r;
        if (x > SAT_HI)
            r = SAT_HI[COORD_WIDTH-1:0];
        else if (x < SAT_LO)
            r = SAT_LO[COORD_WIDTH-1:0];
        else
            r = x[COORD_WIDTH-1:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/sacr_if.sv
// Request and result channel interfaces of the swept box collision block.
interface sacr_box_if;
    logic                                          valid;
    logic                                          ready;
    logic signed [sacr_pkg::COORD_WIDTH-1:0]       mover_x;
    logic signed [sacr_pkg::COORD_WIDTH-1:0]       mover_y;
    logic        [sacr_pkg::SIZE_WIDTH-1:0]        mover_w;
    logic        [sacr_pkg::SIZE_WIDTH-1:0]        mover_h;
    logic signed [sacr_pkg::COORD_WIDTH-1:0]       vel_x;
    logic signed [sacr_pkg::COORD_WIDTH-1:0]       vel_y;
    logic signed [sacr_pkg::COORD_WIDTH-1:0]       target_x;
    logic signed [sacr_pkg::COORD_WIDTH-1:0]       target_y;
    logic        [sacr_pkg::SIZE_WIDTH-1:0]        target_w;
    logic        [sacr_pkg::SIZE_WIDTH-1:0]        target_h;

    modport source (
        output valid, mover_x, mover_y, mover_w, mover_h, vel_x, vel_y,
               target_x, target_y, target_w, target_h,
        input  ready
    );
    modport sink (
        input  valid, mover_x, mover_y, mover_w, mover_h, vel_x, vel_y,
               target_x, target_y, target_w, target_h,
        output ready
    );
endinterface

interface sacr_res_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    hit;
    logic        [sacr_pkg::TIME_BITS-1:0]   entry_time;
    logic signed [sacr_pkg::COORD_WIDTH-1:0] contact_x;
    logic signed [sacr_pkg::COORD_WIDTH-1:0] contact_y;
    logic signed [sacr_pkg::NORM_WIDTH-1:0]  normal_x;
    logic signed [sacr_pkg::NORM_WIDTH-1:0]  normal_y;
    logic signed [sacr_pkg::COORD_WIDTH-1:0] new_vel_x;
    logic signed [sacr_pkg::COORD_WIDTH-1:0] new_vel_y;

    modport source (
        output valid, hit, entry_time, contact_x, contact_y, normal_x, normal_y,
               new_vel_x, new_vel_y,
        input  ready
    );
    modport sink (
        input  valid, hit, entry_time, contact_x, contact_y, normal_x, normal_y,
               new_vel_x, new_vel_y,
        output ready
    );
endinterface

>>> hw/rtl/sacr_slab.sv
// Slab setup, cross products and exact slab comparisons (three stages).
module sacr_slab (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sacr_pkg::in_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sacr_pkg::div_t   out_data
);

    logic           s1_valid_reg;
    logic           s2_valid_reg;
    logic           s3_valid_reg;
    sacr_pkg::s1_t  s1_reg;
    sacr_pkg::s1_t  s1_next;
    sacr_pkg::s2_t  s2_reg;
    sacr_pkg::s2_t  s2_next;
    sacr_pkg::div_t s3_reg;
    sacr_pkg::div_t s3_next;
    logic           en1;
    logic           en2;
    logic           en3;

    assign en3      = !s3_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        s1_next.ax = sacr_pkg::axis_setup(in_data.mover_x, in_data.mover_w, in_data.vel_x,
                                          in_data.target_x, in_data.target_w);
        s1_next.ay = sacr_pkg::axis_setup(in_data.mover_y, in_data.mover_h, in_data.vel_y,
                                          in_data.target_y, in_data.target_h);
        s1_next.vel_x = in_data.vel_x;
        s1_next.vel_y = in_data.vel_y;
        s1_next.ctr_x = sacr_pkg::CTR_WIDTH'(in_data.mover_x)
                      + sacr_pkg::CTR_WIDTH'(in_data.mover_w >> 1);
        s1_next.ctr_y = sacr_pkg::CTR_WIDTH'(in_data.mover_y)
                      + sacr_pkg::CTR_WIDTH'(in_data.mover_h >> 1);
        s1_next.odd_x = in_data.mover_w[0];
        s1_next.odd_y = in_data.mover_h[0];
    end

    always_comb
    begin
        s2_next.s      = s1_reg;
        s2_next.p_xy_a = s1_reg.ax.near_num * $signed({1'b0, s1_reg.ay.den});
        s2_next.p_xy_b = s1_reg.ay.far_num  * $signed({1'b0, s1_reg.ax.den});
        s2_next.p_yx_a = s1_reg.ay.near_num * $signed({1'b0, s1_reg.ax.den});
        s2_next.p_yx_b = s1_reg.ax.far_num  * $signed({1'b0, s1_reg.ay.den});
        s2_next.p_nn_a = s1_reg.ax.near_num * $signed({1'b0, s1_reg.ay.den});
        s2_next.p_nn_b = s1_reg.ay.near_num * $signed({1'b0, s1_reg.ax.den});
    end

    always_comb
    begin
        sacr_pkg::ord_t                         c_xy;
        sacr_pkg::ord_t                         c_yx;
        sacr_pkg::ord_t                         c_nn;
        sacr_pkg::kind_t                        t_kind;
        logic signed [sacr_pkg::DIST_WIDTH-1:0] t_num;
        logic        [sacr_pkg::DEN_WIDTH-1:0]  t_den;
        logic                                   t_ok;
        logic                                   n_ok;
        c_xy = sacr_pkg::cmp_time(s2_reg.s.ax.near_kind, s2_reg.s.ay.far_kind,
                                  s2_reg.p_xy_a, s2_reg.p_xy_b);
        c_yx = sacr_pkg::cmp_time(s2_reg.s.ay.near_kind, s2_reg.s.ax.far_kind,
                                  s2_reg.p_yx_a, s2_reg.p_yx_b);
        c_nn = sacr_pkg::cmp_time(s2_reg.s.ax.near_kind, s2_reg.s.ay.near_kind,
                                  s2_reg.p_nn_a, s2_reg.p_nn_b);
        if (c_nn == sacr_pkg::ORD_LT)
        begin
            t_kind = s2_reg.s.ay.near_kind;
            t_num  = s2_reg.s.ay.near_num;
            t_den  = s2_reg.s.ay.den;
        end
        else
        begin
            t_kind = s2_reg.s.ax.near_kind;
            t_num  = s2_reg.s.ax.near_num;
            t_den  = s2_reg.s.ax.den;
        end
        t_ok = (t_kind == sacr_pkg::KIND_FIN) && !t_num[sacr_pkg::DIST_WIDTH-1]
            && (t_num < $signed({2'b00, t_den}));

        s3_next.ctx.norm_x = '0;
        s3_next.ctx.norm_y = '0;
        n_ok = 1'b1;
        unique case (c_nn)
            sacr_pkg::ORD_LT:
            begin
                s3_next.ctx.norm_y = s2_reg.s.vel_y[sacr_pkg::COORD_WIDTH-1]
                                   ? sacr_pkg::NORM_ONE : -sacr_pkg::NORM_ONE;
            end
            sacr_pkg::ORD_GT:
            begin
                s3_next.ctx.norm_x = s2_reg.s.vel_x[sacr_pkg::COORD_WIDTH-1]
                                   ? sacr_pkg::NORM_ONE : -sacr_pkg::NORM_ONE;
            end
            default:
            begin
                if ((s2_reg.s.vel_x != '0) && (s2_reg.s.vel_y != '0))
                begin
                    s3_next.ctx.norm_x = s2_reg.s.vel_x[sacr_pkg::COORD_WIDTH-1]
                                       ? sacr_pkg::NORM_DIAG : -sacr_pkg::NORM_DIAG;
                    s3_next.ctx.norm_y = s2_reg.s.vel_y[sacr_pkg::COORD_WIDTH-1]
                                       ? sacr_pkg::NORM_DIAG : -sacr_pkg::NORM_DIAG;
                end
                else
                    n_ok = 1'b0;
            end
        endcase

        s3_next.ctx.hit = !s2_reg.s.ax.miss && !s2_reg.s.ay.miss
                        && (c_xy == sacr_pkg::ORD_LT) && (c_yx == sacr_pkg::ORD_LT)
                        && t_ok && n_ok;
        s3_next.ctx.vel_x = s2_reg.s.vel_x;
        s3_next.ctx.vel_y = s2_reg.s.vel_y;
        s3_next.ctx.ctr_x = s2_reg.s.ctr_x;
        s3_next.ctx.ctr_y = s2_reg.s.ctr_y;
        s3_next.ctx.odd_x = s2_reg.s.odd_x;
        s3_next.ctx.odd_y = s2_reg.s.odd_y;
        s3_next.rem       = t_num[sacr_pkg::REM_WIDTH-1:0];
        s3_next.den       = t_den;
        s3_next.tq        = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
            s1_reg <= s1_next;
        if (en2 && s1_valid_reg)
            s2_reg <= s2_next;
        if (en3 && s2_valid_reg)
            s3_reg <= s3_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

endmodule

>>> hw/rtl/sacr_div.sv
// Pipelined restoring divider for the Q0.16 entry time, two quotient bits per stage.
module sacr_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sacr_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output sacr_pkg::div_t out_data
);

    sacr_pkg::div_t                    st_reg [sacr_pkg::DIV_STAGES];
    logic [sacr_pkg::DIV_STAGES-1:0]   valid_reg;
    logic [sacr_pkg::DIV_STAGES:0]     en;

    function automatic sacr_pkg::div_t div_step(input sacr_pkg::div_t d);
        sacr_pkg::div_t                  o;
        logic [sacr_pkg::REM_WIDTH-1:0]  r2;
        logic [sacr_pkg::REM_WIDTH-1:0]  dd;
        o  = d;
        r2 = {d.rem[sacr_pkg::REM_WIDTH-2:0], 1'b0};
        dd = sacr_pkg::REM_WIDTH'(d.den);
        if (r2 >= dd)
        begin
            o.rem = r2 - dd;
            o.tq  = {d.tq[sacr_pkg::TIME_BITS-2:0], 1'b1};
        end
        else
        begin
            o.rem = r2;
            o.tq  = {d.tq[sacr_pkg::TIME_BITS-2:0], 1'b0};
        end
        return o;
    endfunction

    assign en[sacr_pkg::DIV_STAGES] = out_ready;

    for (genvar k = 0; k < sacr_pkg::DIV_STAGES; k++)
    begin : g_stage
        sacr_pkg::div_t src;
        sacr_pkg::div_t st_next;
        logic           src_valid;

        if (k == 0)
        begin : g_first
            assign src       = in_data;
            assign src_valid = in_valid;
        end
        else
        begin : g_rest
            assign src       = st_reg[k-1];
            assign src_valid = valid_reg[k-1];
        end

        always_comb
        begin
            st_next = src;
            for (int i = 0; i < sacr_pkg::DIV_STEPS; i++)
                st_next = div_step(st_next);
        end

        assign en[k] = !valid_reg[k] || en[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en[k])
                valid_reg[k] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en[k] && src_valid)
                st_reg[k] <= st_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[sacr_pkg::DIV_STAGES-1];
    assign out_data  = st_reg[sacr_pkg::DIV_STAGES-1];

endmodule

>>> hw/rtl/sacr_resp.sv
// Contact point and velocity correction (three stages, last one is the output register).
module sacr_resp (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sacr_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output sacr_pkg::out_t out_data
);

    typedef struct packed {
        sacr_pkg::ctx_t                          ctx;
        logic        [sacr_pkg::TIME_BITS-1:0]   tq;
        logic signed [sacr_pkg::CPROD_WIDTH-1:0] cprod_x;
        logic signed [sacr_pkg::CPROD_WIDTH-1:0] cprod_y;
        logic        [sacr_pkg::MPROD_WIDTH-1:0] mprod_x;
        logic        [sacr_pkg::MPROD_WIDTH-1:0] mprod_y;
    } r1_t;

    typedef struct packed {
        sacr_pkg::ctx_t                          ctx;
        logic        [sacr_pkg::TIME_BITS-1:0]   tq;
        logic signed [sacr_pkg::COORD_WIDTH-1:0] contact_x;
        logic signed [sacr_pkg::COORD_WIDTH-1:0] contact_y;
        logic        [sacr_pkg::MAG_WIDTH-1:0]   m_x;
        logic        [sacr_pkg::MAG_WIDTH-1:0]   m_y;
    } r2_t;

    logic           r1_valid_reg;
    logic           r2_valid_reg;
    logic           r3_valid_reg;
    r1_t            r1_reg;
    r1_t            r1_next;
    r2_t            r2_reg;
    r2_t            r2_next;
    sacr_pkg::out_t r3_reg;
    sacr_pkg::out_t r3_next;
    logic           en1;
    logic           en2;
    logic           en3;

    function automatic logic [sacr_pkg::COORD_WIDTH-1:0] abs_vel(
        input logic signed [sacr_pkg::COORD_WIDTH-1:0] v
    );
        return v[sacr_pkg::COORD_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [sacr_pkg::COORD_WIDTH-1:0] contact(
        input logic signed [sacr_pkg::CTR_WIDTH-1:0]   ctr,
        input logic                                    odd,
        input logic signed [sacr_pkg::CPROD_WIDTH-1:0] p
    );
        logic signed [sacr_pkg::CTR_WIDTH-1:0] q;
        logic        [sacr_pkg::TIME_BITS+1:0] frac;
        logic signed [sacr_pkg::SAT_WIDTH-1:0] sum;
        q    = p[sacr_pkg::CPROD_WIDTH-1:sacr_pkg::TIME_BITS];
        frac = {1'b0, odd, {sacr_pkg::TIME_BITS{1'b0}}}
             + {1'b0, p[sacr_pkg::TIME_BITS-1:0], 1'b0}
             + {2'b01, {sacr_pkg::TIME_BITS{1'b0}}};
        sum  = sacr_pkg::SAT_WIDTH'(ctr) + sacr_pkg::SAT_WIDTH'(q)
             + sacr_pkg::SAT_WIDTH'(frac[sacr_pkg::TIME_BITS+1]);
        return sacr_pkg::sat_coord(sum);
    endfunction

    function automatic logic [sacr_pkg::MAG_WIDTH-1:0] round_mag(
        input logic [sacr_pkg::MPROD_WIDTH-1:0] p
    );
        logic [sacr_pkg::MPROD_WIDTH:0] r;
        r = {1'b0, p} + (sacr_pkg::MPROD_WIDTH+1)'(1 << (sacr_pkg::TIME_BITS - 1));
        return r[sacr_pkg::TIME_BITS+sacr_pkg::MAG_WIDTH-1:sacr_pkg::TIME_BITS];
    endfunction

    function automatic logic signed [sacr_pkg::COORD_WIDTH-1:0] correct(
        input logic signed [sacr_pkg::COORD_WIDTH-1:0] v,
        input logic signed [sacr_pkg::NORM_WIDTH-1:0]  n,
        input logic        [sacr_pkg::MAG_WIDTH-1:0]   m
    );
        logic [sacr_pkg::NORM_WIDTH-1:0]                   nabs;
        logic [sacr_pkg::MAG_WIDTH+sacr_pkg::NMAG_WIDTH:0] ap;
        logic [sacr_pkg::MAG_WIDTH+1:0]                    a;
        logic signed [sacr_pkg::SAT_WIDTH-1:0]             s;
        nabs = n[sacr_pkg::NORM_WIDTH-1] ? (~n + 1'b1) : n;
        ap   = m * nabs[sacr_pkg::NMAG_WIDTH-1:0];
        ap   = ap + (sacr_pkg::MAG_WIDTH+sacr_pkg::NMAG_WIDTH+1)'(1 << 13);
        a    = ap[sacr_pkg::MAG_WIDTH+sacr_pkg::NMAG_WIDTH:14];
        if (n[sacr_pkg::NORM_WIDTH-1])
            s = sacr_pkg::SAT_WIDTH'(v) - sacr_pkg::SAT_WIDTH'(a);
        else
            s = sacr_pkg::SAT_WIDTH'(v) + sacr_pkg::SAT_WIDTH'(a);
        return (n == '0) ? v : sacr_pkg::sat_coord(s);
    endfunction

    assign en3      = !r3_valid_reg || out_ready;
    assign en2      = !r2_valid_reg || en3;
    assign en1      = !r1_valid_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        logic [sacr_pkg::TIME_BITS:0] comp;
        comp            = {1'b1, {sacr_pkg::TIME_BITS{1'b0}}} - {1'b0, in_data.tq};
        r1_next.ctx     = in_data.ctx;
        r1_next.tq      = in_data.tq;
        r1_next.cprod_x = in_data.ctx.vel_x * $signed({1'b0, in_data.tq});
        r1_next.cprod_y = in_data.ctx.vel_y * $signed({1'b0, in_data.tq});
        r1_next.mprod_x = abs_vel(in_data.ctx.vel_x) * comp;
        r1_next.mprod_y = abs_vel(in_data.ctx.vel_y) * comp;
    end

    always_comb
    begin
        r2_next.ctx       = r1_reg.ctx;
        r2_next.tq        = r1_reg.tq;
        r2_next.contact_x = contact(r1_reg.ctx.ctr_x, r1_reg.ctx.odd_x, r1_reg.cprod_x);
        r2_next.contact_y = contact(r1_reg.ctx.ctr_y, r1_reg.ctx.odd_y, r1_reg.cprod_y);
        r2_next.m_x       = round_mag(r1_reg.mprod_x);
        r2_next.m_y       = round_mag(r1_reg.mprod_y);
    end

    always_comb
    begin
        r3_next.hit = r2_reg.ctx.hit;
        if (r2_reg.ctx.hit)
        begin
            r3_next.entry_time = r2_reg.tq;
            r3_next.contact_x  = r2_reg.contact_x;
            r3_next.contact_y  = r2_reg.contact_y;
            r3_next.normal_x   = r2_reg.ctx.norm_x;
            r3_next.normal_y   = r2_reg.ctx.norm_y;
            r3_next.new_vel_x  = correct(r2_reg.ctx.vel_x, r2_reg.ctx.norm_x, r2_reg.m_x);
            r3_next.new_vel_y  = correct(r2_reg.ctx.vel_y, r2_reg.ctx.norm_y, r2_reg.m_y);
        end
        else
        begin
            r3_next.entry_time = '0;
            r3_next.contact_x  = '0;
            r3_next.contact_y  = '0;
            r3_next.normal_x   = '0;
            r3_next.normal_y   = '0;
            r3_next.new_vel_x  = r2_reg.ctx.vel_x;
            r3_next.new_vel_y  = r2_reg.ctx.vel_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                r1_valid_reg <= in_valid;
            if (en2)
                r2_valid_reg <= r1_valid_reg;
            if (en3)
                r3_valid_reg <= r2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
            r1_reg <= r1_next;
        if (en2 && r1_valid_reg)
            r2_reg <= r2_next;
        if (en3 && r2_valid_reg)
            r3_reg <= r3_next;
    end

    assign out_valid = r3_valid_reg;
    assign out_data  = r3_reg;

endmodule

>>> hw/rtl/swept_aabb_collision_resolve.sv
// Top level of the swept box collision block: slab test, entry time divider, response.
//
// One request per clock cycle is accepted and one result leaves per cycle while the result
// channel is ready; there are 3 slab stages, 8 divider stages and 3 response stages. The
// divider depth is set by the 16-bit restoring division of the entry time, two quotient
// bits per stage. Each stage holds its request while the next one is full, so back
// pressure on the result channel fills bubbles first and then stalls the request channel;
// nothing is lost. Slab times are compared exactly by cross multiplication; contact and
// corrected velocity saturate to the coordinate range.
module swept_aabb_collision_resolve (
    input  logic       clk,
    input  logic       rst_n,
    sacr_box_if.sink   boxes,
    sacr_res_if.source result
);

    sacr_pkg::in_t  in_data;
    sacr_pkg::div_t slab_data;
    sacr_pkg::div_t div_data;
    sacr_pkg::out_t out_data;
    logic           slab_valid;
    logic           slab_ready;
    logic           div_valid;
    logic           div_ready;

    always_comb
    begin
        in_data.mover_x  = boxes.mover_x;
        in_data.mover_y  = boxes.mover_y;
        in_data.mover_w  = boxes.mover_w;
        in_data.mover_h  = boxes.mover_h;
        in_data.vel_x    = boxes.vel_x;
        in_data.vel_y    = boxes.vel_y;
        in_data.target_x = boxes.target_x;
        in_data.target_y = boxes.target_y;
        in_data.target_w = boxes.target_w;
        in_data.target_h = boxes.target_h;
    end

    sacr_slab u_slab (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (boxes.valid),
        .in_ready  (boxes.ready),
        .in_data   (in_data),
        .out_valid (slab_valid),
        .out_ready (slab_ready),
        .out_data  (slab_data)
    );

    sacr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (slab_valid),
        .in_ready  (slab_ready),
        .in_data   (slab_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    sacr_resp u_resp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    assign result.hit        = out_data.hit;
    assign result.entry_time = out_data.entry_time;
    assign result.contact_x  = out_data.contact_x;
    assign result.contact_y  = out_data.contact_y;
    assign result.normal_x   = out_data.normal_x;
    assign result.normal_y   = out_data.normal_y;
    assign result.new_vel_x  = out_data.new_vel_x;
    assign result.new_vel_y  = out_data.new_vel_y;

endmodule

>>> tb/sacr_tb_if.sv
`timescale 1ns / 100ps
// Result record type shared by the testbench of the swept box collision block.
package sacr_tb_types;
    typedef struct {
        logic                                    hit;
        logic        [sacr_pkg::TIME_BITS-1:0]   entry_time;
        logic signed [sacr_pkg::COORD_WIDTH-1:0] contact_x;
        logic signed [sacr_pkg::COORD_WIDTH-1:0] contact_y;
        logic signed [sacr_pkg::NORM_WIDTH-1:0]  normal_x;
        logic signed [sacr_pkg::NORM_WIDTH-1:0]  normal_y;
        logic signed [sacr_pkg::COORD_WIDTH-1:0] new_vel_x;
        logic signed [sacr_pkg::COORD_WIDTH-1:0] new_vel_y;
    } resolve_t;
endpackage

>>> tb/tb_swept_aabb_collision_resolve.sv
`timescale 1ns / 100ps
// Self-checking testbench of the swept box collision block with a bit-true collision predictor.
module tb_swept_aabb_collision_resolve;

    localparam longint CHI = (64'sd1 <<< (sacr_pkg::COORD_WIDTH - 1)) - 1;
    localparam longint CLO = -CHI - 1;
    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;
    sacr_box_if boxes ();
    sacr_res_if result ();

    swept_aabb_collision_resolve dut (
        .clk(clk),
        .rst_n(rst_n),
        .boxes(boxes.sink),
        .result(result.source)
    );

    typedef struct {
        int     knd;
        longint num;
        longint den;
    } stime_t;

    typedef struct {
        sacr_pkg::in_t           req;
        logic                    known;
        sacr_tb_types::resolve_t res;
    } row_t;

    sacr_tb_types::resolve_t expected_q[$];
    row_t     rows[$];
    int       errors = 0;
    int       idle_cycles = 0;
    int       recv_idle = 0;
    bit       recv_hold = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clamp(longint x);
        return x > CHI ? CHI : (x < CLO ? CLO : x);
    endfunction

    function automatic stime_t slab_time(longint d, longint v);
        stime_t t;
        t.knd = 0;
        t.num = d;
        t.den = v;
        if (v < 0)
        begin
            t.num = -d;
            t.den = -v;
        end
        else if (v == 0)
        begin
            t.knd = d > 0 ? 1 : -1;
            t.num = 0;
            t.den = 1;
        end
        return t;
    endfunction

    function automatic int order(stime_t a, stime_t b);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        if (a.knd != b.knd)
            return a.knd < b.knd ? -1 : 1;
        if (a.knd != 0)
            return 0;
        pa = 128'(a.num) * 128'(b.den);
        pb = 128'(b.num) * 128'(a.den);
        return pa < pb ? -1 : (pa == pb ? 0 : 1);
    endfunction

    function automatic longint contact_at(longint pos, longint size, longint v, longint tq);
        longint p;
        longint r;
        longint fr;
        p = v * tq;
        r = p & 64'hFFFF;
        fr = ((size & 1) <<< 16) + 2 * r + 65536;
        return clamp(pos + (size >>> 1) + (p - r) / 65536 + (fr >>> 17));
    endfunction

    function automatic longint slide_vel(longint v, longint n, longint tq);
        longint mag;
        longint an;
        longint m;
        longint a;
        if (n == 0)
            return v;
        mag = v < 0 ? -v : v;
        an = n < 0 ? -n : n;
        m = (mag * (65536 - tq) + 32768) >>> 16;
        a = (m * an + 8192) >>> 14;
        return clamp(n > 0 ? v + a : v - a);
    endfunction

    function automatic sacr_tb_types::resolve_t resolve_sweep(sacr_pkg::in_t b);
        sacr_tb_types::resolve_t o;
        longint mx, my, mw, mh, vx, vy, tx, ty, tw, th;
        longint dnx, dfx, dny, dfy, nrx, nry, rm, tq;
        stime_t nx, fx, ny, fy, tmp, t;
        int c;
        mx = longint'(b.mover_x);
        my = longint'(b.mover_y);
        mw = longint'(b.mover_w);
        mh = longint'(b.mover_h);
        vx = longint'(b.vel_x);
        vy = longint'(b.vel_y);
        tx = longint'(b.target_x);
        ty = longint'(b.target_y);
        tw = longint'(b.target_w);
        th = longint'(b.target_h);
        dnx = tx - mx - mw;
        dfx = tx + tw - mx;
        dny = ty - my - mh;
        dfy = ty + th - my;
        nrx = 0;
        nry = 0;
        tq = 0;
        o = '{hit: 1'b0, entry_time: '0, contact_x: '0, contact_y: '0,
              normal_x: '0, normal_y: '0, new_vel_x: b.vel_x, new_vel_y: b.vel_y};
        if ((vx == 0 && (dnx == 0 || dfx == 0)) || (vy == 0 && (dny == 0 || dfy == 0)))
            return o;
        nx = slab_time(dnx, vx);
        fx = slab_time(dfx, vx);
        ny = slab_time(dny, vy);
        fy = slab_time(dfy, vy);
        if (order(nx, fx) > 0)
        begin
            tmp = nx;
            nx = fx;
            fx = tmp;
        end
        if (order(ny, fy) > 0)
        begin
            tmp = ny;
            ny = fy;
            fy = tmp;
        end
        if (order(nx, fy) >= 0 || order(ny, fx) >= 0)
            return o;
        c = order(nx, ny);
        if (c >= 0)
            t = nx;
        else
            t = ny;
        if (t.knd != 0 || t.num < 0 || t.num >= t.den)
            return o;
        if (c < 0)
            nry = vy < 0 ? sacr_pkg::NORM_ONE : -sacr_pkg::NORM_ONE;
        else if (c > 0)
            nrx = vx < 0 ? sacr_pkg::NORM_ONE : -sacr_pkg::NORM_ONE;
        else if (vx != 0 && vy != 0)
        begin
            nrx = vx < 0 ? sacr_pkg::NORM_DIAG : -sacr_pkg::NORM_DIAG;
            nry = vy < 0 ? sacr_pkg::NORM_DIAG : -sacr_pkg::NORM_DIAG;
        end
        else
            return o;
        rm = t.num;
        for (int i = 0; i < sacr_pkg::TIME_BITS; i++)
        begin
            rm = rm <<< 1;
            tq = tq <<< 1;
            if (rm >= t.den)
            begin
                rm -= t.den;
                tq |= 1;
            end
        end
        o.hit = 1'b1;
        o.entry_time = sacr_pkg::TIME_BITS'(tq);
        o.contact_x = sacr_pkg::COORD_WIDTH'(contact_at(mx, mw, vx, tq));
        o.contact_y = sacr_pkg::COORD_WIDTH'(contact_at(my, mh, vy, tq));
        o.normal_x = sacr_pkg::NORM_WIDTH'(nrx);
        o.normal_y = sacr_pkg::NORM_WIDTH'(nry);
        o.new_vel_x = sacr_pkg::COORD_WIDTH'(slide_vel(vx, nrx, tq));
        o.new_vel_y = sacr_pkg::COORD_WIDTH'(slide_vel(vy, nry, tq));
        return o;
    endfunction

    function automatic sacr_pkg::in_t box_pair(longint mx, longint my, longint mw,
                                               longint mh, longint vx, longint vy,
                                               longint tx, longint ty, longint tw,
                                               longint th);
        sacr_pkg::in_t b;
        b.mover_x = sacr_pkg::COORD_WIDTH'(mx);
        b.mover_y = sacr_pkg::COORD_WIDTH'(my);
        b.mover_w = sacr_pkg::SIZE_WIDTH'(mw);
        b.mover_h = sacr_pkg::SIZE_WIDTH'(mh);
        b.vel_x = sacr_pkg::COORD_WIDTH'(vx);
        b.vel_y = sacr_pkg::COORD_WIDTH'(vy);
        b.target_x = sacr_pkg::COORD_WIDTH'(tx);
        b.target_y = sacr_pkg::COORD_WIDTH'(ty);
        b.target_w = sacr_pkg::SIZE_WIDTH'(tw);
        b.target_h = sacr_pkg::SIZE_WIDTH'(th);
        return b;
    endfunction

    function automatic sacr_tb_types::resolve_t no_hit(sacr_pkg::in_t b);
        sacr_tb_types::resolve_t o;
        o = '{hit: 1'b0, entry_time: '0, contact_x: '0, contact_y: '0,
              normal_x: '0, normal_y: '0, new_vel_x: b.vel_x, new_vel_y: b.vel_y};
        return o;
    endfunction

    function automatic logic [31:0] rnd_bits();
        return $urandom;
    endfunction

    function automatic sacr_pkg::in_t random_pair();
        sacr_pkg::in_t b;
        logic [255:0]  raw;
        longint        sc;
        raw = {rnd_bits(), rnd_bits(), rnd_bits(), rnd_bits(), rnd_bits(),
               rnd_bits(), rnd_bits(), rnd_bits()};
        b = raw[$bits(sacr_pkg::in_t)-1:0];
        if ($urandom_range(0, 9) < 7)
        begin
            // near pair at a random scale so that hits are common
            sc = 64'sd1 <<< $urandom_range(4, 20);
            b.mover_w = sacr_pkg::SIZE_WIDTH'($urandom_range(0, 3) == 0 ? 0 : $urandom % sc);
            b.mover_h = sacr_pkg::SIZE_WIDTH'($urandom_range(0, 3) == 0 ? 0 : $urandom % sc);
            b.target_w = sacr_pkg::SIZE_WIDTH'($urandom % sc);
            b.target_h = sacr_pkg::SIZE_WIDTH'($urandom % sc);
            b.mover_x = sacr_pkg::COORD_WIDTH'(longint'(b.target_x)
                                               - longint'($urandom % (4 * sc)) + sc);
            b.mover_y = sacr_pkg::COORD_WIDTH'(longint'(b.target_y)
                                               - longint'($urandom % (4 * sc)) + sc);
            b.vel_x = sacr_pkg::COORD_WIDTH'($urandom_range(0, 4) == 0 ? 0 :
                                             longint'($urandom % (8 * sc)) - 4 * sc);
            b.vel_y = sacr_pkg::COORD_WIDTH'($urandom_range(0, 4) == 0 ? 0 :
                                             longint'($urandom % (8 * sc)) - 4 * sc);
            if ($urandom_range(0, 5) == 0)
            begin
                // exact corner approach on a diagonal
                b.vel_y = b.vel_x;
                b.mover_y = sacr_pkg::COORD_WIDTH'(longint'(b.target_y)
                                                   - longint'(b.mover_h)
                                                   - longint'(b.target_x)
                                                   + longint'(b.mover_x)
                                                   + longint'(b.mover_w));
            end
        end
        return b;
    endfunction

    task automatic send_request(sacr_pkg::in_t b, sacr_tb_types::resolve_t exp_r);
        boxes.valid <= 1'b1;
        boxes.mover_x <= b.mover_x;
        boxes.mover_y <= b.mover_y;
        boxes.mover_w <= b.mover_w;
        boxes.mover_h <= b.mover_h;
        boxes.vel_x <= b.vel_x;
        boxes.vel_y <= b.vel_y;
        boxes.target_x <= b.target_x;
        boxes.target_y <= b.target_y;
        boxes.target_w <= b.target_w;
        boxes.target_h <= b.target_h;
        expected_q.push_back(exp_r);
        @(posedge clk);
        while (!boxes.ready)
            @(posedge clk);
    endtask

    task automatic send_rows(int send_pct, int recv_pct, int count);
        row_t          r;
        sacr_pkg::in_t b;
        recv_idle = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (rows.size() != 0)
            begin
                r = rows.pop_front();
                if (r.known)
                    send_request(r.req, r.res);
                else
                    send_request(r.req, resolve_sweep(r.req));
            end
            else
            begin
                b = random_pair();
                send_request(b, resolve_sweep(b));
            end
            if ($urandom_range(0, 99) < send_pct)
            begin
                boxes.valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(0, 99) < send_pct)
                    @(posedge clk);
            end
        end
    endtask

    // receiver readiness
    always @(posedge clk)
    begin
        result.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        sacr_tb_types::resolve_t exp_r;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with none expected");
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (result.hit !== exp_r.hit)
                begin
                    $error("hit exp %0d got %0d", exp_r.hit, result.hit);
                    errors++;
                end
                if (result.entry_time !== exp_r.entry_time)
                begin
                    $error("entry_time exp %0d got %0d", exp_r.entry_time, result.entry_time);
                    errors++;
                end
                if (result.contact_x !== exp_r.contact_x)
                begin
                    $error("contact_x exp %0d got %0d", exp_r.contact_x, result.contact_x);
                    errors++;
                end
                if (result.contact_y !== exp_r.contact_y)
                begin
                    $error("contact_y exp %0d got %0d", exp_r.contact_y, result.contact_y);
                    errors++;
                end
                if (result.normal_x !== exp_r.normal_x)
                begin
                    $error("normal_x exp %0d got %0d", exp_r.normal_x, result.normal_x);
                    errors++;
                end
                if (result.normal_y !== exp_r.normal_y)
                begin
                    $error("normal_y exp %0d got %0d", exp_r.normal_y, result.normal_y);
                    errors++;
                end
                if (result.new_vel_x !== exp_r.new_vel_x)
                begin
                    $error("new_vel_x exp %0d got %0d", exp_r.new_vel_x, result.new_vel_x);
                    errors++;
                end
                if (result.new_vel_y !== exp_r.new_vel_y)
                begin
                    $error("new_vel_y exp %0d got %0d", exp_r.new_vel_y, result.new_vel_y);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((boxes.valid && boxes.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic load_directed();
        sacr_pkg::in_t b;
        // axis hit from the left at t = 1/2
        rows.push_back('{box_pair(0, 0, 256, 256, 512, 0, 512, 0, 256, 256), 1'b0, no_hit(b)});
        // axis hit from the right and from below, above
        rows.push_back('{box_pair(1024, 0, 256, 256, -512, 0, 0, 0, 512, 256), 1'b0, no_hit(b)});
        rows.push_back('{box_pair(0, 0, 256, 256, 0, 1024, 0, 512, 256, 256), 1'b0, no_hit(b)});
        rows.push_back('{box_pair(0, 1024, 256, 256, 0, -900, 0, 0, 256, 256), 1'b0, no_hit(b)});
        // exact corner tie, both axes and one axis
        rows.push_back('{box_pair(0, 0, 256, 256, 512, 512, 512, 512, 256, 256), 1'b0,
                         no_hit(b)});
        rows.push_back('{box_pair(0, 0, 256, 256, -512, -512, -768, -768, 256, 256), 1'b0,
                         no_hit(b)});
        b = box_pair(0, 0, 256, 256, 512, 0, 512, 256, 256, 256);
        rows.push_back('{b, 1'b1, no_hit(b)});
        // zero velocity with zero distance, and zero velocity apart
        b = box_pair(0, 0, 256, 256, 0, 512, 256, 512, 256, 256);
        rows.push_back('{b, 1'b1, no_hit(b)});
        b = box_pair(0, 0, 256, 256, 0, 0, 4096, 4096, 256, 256);
        rows.push_back('{b, 1'b1, no_hit(b)});
        // already overlapping: entry before start
        b = box_pair(0, 0, 512, 512, 100, 100, 256, 256, 256, 256);
        rows.push_back('{b, 1'b1, no_hit(b)});
        // entry exactly at frame end
        b = box_pair(0, 0, 256, 256, 256, 0, 512, 0, 256, 256);
        rows.push_back('{b, 1'b1, no_hit(b)});
        // slabs not overlapping
        b = box_pair(0, 0, 256, 256, 512, 512, 512, 2048, 256, 256);
        rows.push_back('{b, 1'b1, no_hit(b)});
        // extremes, saturation
        rows.push_back('{box_pair(CLO, CLO, CHI, CHI, CHI, CHI, CHI, CHI, CHI, CHI), 1'b0,
                         no_hit(b)});
        rows.push_back('{box_pair(CHI, CHI, CHI, CHI, CLO, CLO, CLO, CLO, CHI, CHI), 1'b0,
                         no_hit(b)});
        rows.push_back('{box_pair(CLO, 0, CHI, 0, CHI, 1, 0, 0, 0, CHI), 1'b0, no_hit(b)});
        rows.push_back('{box_pair(CHI, CLO, 0, CHI, CLO, -1, CLO, CLO, CHI, 0), 1'b0,
                         no_hit(b)});
        rows.push_back('{box_pair(-1, -1, 1, 1, 3, 3, 1, 1, 0, 0), 1'b0, no_hit(b)});
        b = box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        rows.push_back('{b, 1'b1, no_hit(b)});
    endtask

    initial
    begin
        rst_n = 1'b0;
        boxes.valid = 1'b0;
        {boxes.mover_x, boxes.mover_y, boxes.mover_w, boxes.mover_h} = '0;
        {boxes.vel_x, boxes.vel_y, boxes.target_x, boxes.target_y} = '0;
        {boxes.target_w, boxes.target_h} = '0;
        load_directed();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_rows(6, 72, 260);
        send_rows(72, 6, 250);
        // long receiver hold-off while requests keep coming
        fork
            begin
                recv_hold = 1'b1;
                repeat (80) @(posedge clk);
                recv_hold = 1'b0;
            end
            send_rows(0, 0, 60);
        join
        send_rows(0, 0, 200);
        boxes.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> swept_aabb_collision_resolve.f
hw/rtl/sacr_pkg.sv
hw/rtl/sacr_if.sv
hw/rtl/sacr_slab.sv
hw/rtl/sacr_div.sv
hw/rtl/sacr_resp.sv
hw/rtl/swept_aabb_collision_resolve.sv
tb/sacr_tb_if.sv
tb/tb_swept_aabb_collision_resolve.sv
